// ----- sv/grid_signal_propagation_macros.svh -----
// assertion macros for the grid signal propagation block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef GRID_SIGNAL_PROPAGATION_MACROS_SVH
`define GRID_SIGNAL_PROPAGATION_MACROS_SVH

// property must hold at every clock edge outside reset
`define GSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define GSP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- sv/gsp_pkg.sv -----
// shared types and constants for the grid signal propagation block
// no dependencies
package gsp_pkg;

  localparam int GridRows  = 32;
  localparam int GridCols  = 32;
  localparam int CellCount = GridRows * GridCols;
  localparam int RowIdxW   = $clog2(GridRows);
  localparam int ColIdxW   = $clog2(GridCols);
  localparam int CntW      = $clog2(CellCount);

  localparam logic [2:0] KEmpty   = 3'd0;
  localparam logic [2:0] KWireOff = 3'd1;
  localparam logic [2:0] KWireOn  = 3'd2;
  localparam logic [2:0] KSource  = 3'd3;
  localparam logic [2:0] KLampOff = 3'd4;
  localparam logic [2:0] KLampOn  = 3'd5;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_PROP
  } state_e;

  typedef struct packed {
    logic clear;
    logic unpower;
    logic step;
  } cell_ctl_t;

  typedef struct packed {
    cell_ctl_t cell_ctl;
    logic      write;
    logic      load_row;
    logic      respond;
  } gsp_cmd_t;

endpackage

// ----- sv/gsp_cell.sv -----
// one grid cell: holds its kind and takes power from its four neighbors
// depends on gsp_pkg
module gsp_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gsp_pkg::cell_ctl_t ctl_i,
  input  logic              we_i,
  input  logic [2:0]        wr_kind_i,
  input  logic [3:0]        nb_pow_i,
  output logic [2:0]        kind_o,
  output logic              pow_o
);
  import gsp_pkg::*;

  logic [2:0] kind_q, kind_d;

  always_comb begin
    kind_d = kind_q;
    priority if (ctl_i.clear) begin
      kind_d = KEmpty;
    end else if (we_i) begin
      kind_d = wr_kind_i;
    end else if (ctl_i.unpower) begin
      if (kind_q == KWireOn) kind_d = KWireOff;
      else if (kind_q == KLampOn) kind_d = KLampOff;
    end else if (ctl_i.step && (|nb_pow_i)) begin
      if (kind_q == KWireOff) kind_d = KWireOn;
      else if (kind_q == KLampOff) kind_d = KLampOn;
    end else begin
      kind_d = kind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KEmpty;
    end else begin
      kind_q <= kind_d;
    end
  end

  assign kind_o = kind_q;
  assign pow_o  = (kind_q == KWireOn) || (kind_q == KSource);

endmodule

// ----- sv/gsp_ctrl.sv -----
// request sequencer: write, read, clear and tick propagation steps
// depends on gsp_pkg and grid_signal_propagation_macros.svh
module gsp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             run_mode_i,
  input  gsp_pkg::req_e    req_i,
  output logic             busy,
  output gsp_pkg::gsp_cmd_t cmd_o
);
  import gsp_pkg::*;
  `include "grid_signal_propagation_macros.svh"

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              last_step;
  logic              cmd_clash;

  assign last_step = (cnt_q == CntW'(CellCount - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_EXEC;
      ST_EXEC: begin
        if (req_i == REQ_READ) state_d = ST_READ;
        else if (req_i == REQ_TICK && run_mode_i) state_d = ST_PROP;
        else state_d = ST_IDLE;
      end
      ST_READ: state_d = ST_IDLE;
      ST_PROP: if (last_step) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cnt_d = cnt_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_EXEC: begin
        cnt_d                  = '0;
        cmd_o.write            = (req_i == REQ_WRITE);
        cmd_o.cell_ctl.clear   = (req_i == REQ_CLEAR);
        cmd_o.load_row         = (req_i == REQ_READ);
        cmd_o.cell_ctl.unpower = (req_i == REQ_TICK) && run_mode_i;
        cmd_o.respond          = (req_i == REQ_WRITE) || (req_i == REQ_CLEAR) ||
                                 ((req_i == REQ_TICK) && !run_mode_i);
      end
      ST_READ: cmd_o.respond = 1'b1;
      ST_PROP: begin
        cmd_o.cell_ctl.step = 1'b1;
        cmd_o.respond       = last_step;
        cnt_d               = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  assign cmd_clash = (cmd_o.write && cmd_o.cell_ctl.clear) ||
                     (cmd_o.cell_ctl.step && cmd_o.cell_ctl.unpower);

  `GSP_ASSERT(a_accept_busy, (start && !busy) |=> (state_q == ST_EXEC), "accept not taken")
  `GSP_ASSERT(a_prop_ends, (state_q == ST_PROP && last_step) |=> (state_q == ST_IDLE), "tick overrun")
  `GSP_ASSERT_NEVER(a_one_cmd, cmd_clash, "conflicting cell commands")

endmodule

// ----- sv/grid_signal_propagation.sv -----
// latency: write, clear and edit-mode tick answer 2 cycles after start, read 3 cycles,
// run-mode tick 2 + GridRows*GridCols cycles (1026 at 32x32), one propagation step per cycle
// throughput: one transaction at a time; busy stays high until the result strobe
// the result is shown for one cycle on done_o; the receiver cannot stall
// reset clears every cell to empty and run_mode to edit mode
// top level: grid of gsp_cell, gsp_ctrl sequencer, row/column read path
module grid_signal_propagation (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type_i,
  input  logic [4:0] row_i,
  input  logic [4:0] col_i,
  input  logic [2:0] cell_kind_i,
  input  logic       cfg_we_i,
  input  logic       run_mode_i,
  output logic       done_o,
  output logic [1:0] resp_type_o,
  output logic [2:0] cell_value_o
);
  import gsp_pkg::*;

  logic       run_mode_q;
  logic [1:0] req_q;
  logic [4:0] row_q, col_q;
  logic [2:0] kind_q;
  gsp_cmd_t   cmd;
  logic       in_grid, wr_ok;

  logic [2:0] kinds [GridRows][GridCols];
  logic       pow   [GridRows][GridCols];
  logic [2:0] row_data_q [GridCols];

  logic [RowIdxW-1:0] row_idx;
  logic [ColIdxW-1:0] col_idx;

  logic       done_q;
  logic [1:0] resp_type_q;
  logic [2:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      run_mode_q <= run_mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q  <= req_type_i;
      row_q  <= row_i;
      col_q  <= col_i;
      kind_q <= cell_kind_i;
    end
  end

  gsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .run_mode_i (run_mode_q),
    .req_i      (req_e'(req_q)),
    .busy       (busy),
    .cmd_o      (cmd)
  );

  assign in_grid = (int'(row_q) < GridRows) && (int'(col_q) < GridCols);
  assign wr_ok   = cmd.write && in_grid && (kind_q <= KLampOn);
  assign row_idx = RowIdxW'(row_q);
  assign col_idx = ColIdxW'(col_q);

  for (genvar r = 0; r < GridRows; r++) begin : g_row
    for (genvar c = 0; c < GridCols; c++) begin : g_col
      logic [3:0] nb;
      logic       we;

      if (r < GridRows - 1) begin : g_s
        assign nb[0] = pow[r+1][c];
      end else begin : g_s_edge
        assign nb[0] = 1'b0;
      end
      if (r > 0) begin : g_n
        assign nb[1] = pow[r-1][c];
      end else begin : g_n_edge
        assign nb[1] = 1'b0;
      end
      if (c < GridCols - 1) begin : g_e
        assign nb[2] = pow[r][c+1];
      end else begin : g_e_edge
        assign nb[2] = 1'b0;
      end
      if (c > 0) begin : g_w
        assign nb[3] = pow[r][c-1];
      end else begin : g_w_edge
        assign nb[3] = 1'b0;
      end

      assign we = wr_ok && (row_idx == RowIdxW'(r)) && (col_idx == ColIdxW'(c));

      gsp_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctl_i     (cmd.cell_ctl),
        .we_i      (we),
        .wr_kind_i (kind_q),
        .nb_pow_i  (nb),
        .kind_o    (kinds[r][c]),
        .pow_o     (pow[r][c])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_row) begin
      for (int c = 0; c < GridCols; c++) begin
        row_data_q[c] <= kinds[row_idx][c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd.respond;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.respond) begin
      resp_type_q <= req_q;
      value_q     <= (req_q == REQ_READ && in_grid) ? row_data_q[col_idx] : KEmpty;
    end
  end

  assign done_o       = done_q;
  assign resp_type_o  = resp_type_q;
  assign cell_value_o = value_q;

endmodule

// ----- test/tb_grid_signal_propagation.sv -----
// self-checking testbench for grid_signal_propagation: directed and random requests,
// every result checked against an in-bench model of the cell grid and its tick propagation
// depends on gsp_pkg and the grid_signal_propagation top level
`timescale 1ns / 1ps

module tb_grid_signal_propagation;
  import gsp_pkg::*;

  localparam int CycleLimit = 2_000_000;

  typedef enum int {
    ACT_REQ,
    ACT_CFG,
    ACT_DRAIN
  } act_e;

  typedef struct {
    act_e       act;
    req_e       req;
    logic [4:0] row;
    logic [4:0] col;
    logic [2:0] kind;
    logic       mode;
    int         gap;
  } stim_t;

  typedef struct {
    req_e       req;
    logic [2:0] value;
  } resp_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] req_type_i = 2'd0;
  logic [4:0] row_i = 5'd0;
  logic [4:0] col_i = 5'd0;
  logic [2:0] cell_kind_i = 3'd0;
  logic       cfg_we_i = 1'b0;
  logic       run_mode_i = 1'b0;
  logic       done_o;
  logic [1:0] resp_type_o;
  logic [2:0] cell_value_o;

  stim_t      req_stream_q[$];
  resp_t      pending_resp_q[$];
  logic [2:0] cells_q[GridRows][GridCols];
  logic       run_mode_q = 1'b0;
  logic       item_taken = 1'b0;
  int         phase_gap = 0;
  int         err_cnt = 0;

  grid_signal_propagation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_kind_i (cell_kind_i),
    .cfg_we_i    (cfg_we_i),
    .run_mode_i  (run_mode_i),
    .done_o      (done_o),
    .resp_type_o (resp_type_o),
    .cell_value_o(cell_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // grid model: applies one request and returns the expected cell value
  function automatic logic [2:0] apply_request(req_e req, logic [4:0] row, logic [4:0] col,
                                               logic [2:0] kind);
    logic [2:0] value;
    int         work_q[$];
    int         r;
    int         c;
    int         nr;
    int         nc;
    int         pos;
    value = KEmpty;
    case (req)
      REQ_WRITE: begin
        if (int'(row) < GridRows && int'(col) < GridCols && kind <= KLampOn)
          cells_q[row][col] = kind;
      end
      REQ_READ: begin
        if (int'(row) < GridRows && int'(col) < GridCols)
          value = cells_q[row][col];
      end
      REQ_TICK: begin
        if (run_mode_q) begin
          for (r = 0; r < GridRows; r++)
            for (c = 0; c < GridCols; c++) begin
              if (cells_q[r][c] == KWireOn) cells_q[r][c] = KWireOff;
              else if (cells_q[r][c] == KLampOn) cells_q[r][c] = KLampOff;
            end
          for (r = 0; r < GridRows; r++)
            for (c = 0; c < GridCols; c++)
              if (cells_q[r][c] == KSource) work_q.push_back(r * GridCols + c);
          while (work_q.size() > 0) begin
            pos = work_q.pop_front();
            r = pos / GridCols;
            c = pos % GridCols;
            for (int d = 0; d < 4; d++) begin
              nr = r + ((d == 0) ? 1 : (d == 1) ? -1 : 0);
              nc = c + ((d == 2) ? 1 : (d == 3) ? -1 : 0);
              if (nr >= 0 && nr < GridRows && nc >= 0 && nc < GridCols) begin
                if (cells_q[nr][nc] == KWireOff) begin
                  cells_q[nr][nc] = KWireOn;
                  work_q.push_back(nr * GridCols + nc);
                end else if (cells_q[nr][nc] == KLampOff) begin
                  cells_q[nr][nc] = KLampOn;
                end
              end
            end
          end
        end
      end
      default: begin
        for (r = 0; r < GridRows; r++)
          for (c = 0; c < GridCols; c++)
            cells_q[r][c] = KEmpty;
      end
    endcase
    return value;
  endfunction

  // monitor: model update on config writes and accepted transactions, result checks
  always @(posedge clk_i) begin
    resp_t got;
    if (!rst_ni) begin
      for (int r = 0; r < GridRows; r++)
        for (int c = 0; c < GridCols; c++)
          cells_q[r][c] = KEmpty;
      run_mode_q = 1'b0;
      item_taken <= 1'b0;
    end else begin
      if (cfg_we_i) run_mode_q = run_mode_i;
      if (done_o) begin
        if (pending_resp_q.size() == 0) begin
          $error("result with no transaction outstanding: resp_type %0d cell_value %0d",
                 resp_type_o, cell_value_o);
          err_cnt++;
        end else begin
          got = pending_resp_q.pop_front();
          if (resp_type_o !== got.req) begin
            $error("resp_type: expected %0d, actual %0d", got.req, resp_type_o);
            err_cnt++;
          end
          if (cell_value_o !== got.value) begin
            $error("cell_value: expected %0d, actual %0d", got.value, cell_value_o);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        got.req = req_e'(req_type_i);
        got.value = apply_request(req_e'(req_type_i), row_i, col_i, cell_kind_i);
        pending_resp_q.push_back(got);
      end
      item_taken <= start && !busy;
    end
  end

  // driver: holds each transaction until accepted, config writes only when idle
  always @(negedge clk_i) begin
    logic  nxt_start;
    logic  nxt_we;
    stim_t p;
    if (rst_ni) begin
      nxt_start = start;
      nxt_we = 1'b0;
      if (start && item_taken) nxt_start = 1'b0;
      if (!nxt_start && req_stream_q.size() > 0) begin
        p = req_stream_q[0];
        case (p.act)
          ACT_REQ: begin
            if ($urandom_range(99) >= p.gap) begin
              void'(req_stream_q.pop_front());
              req_type_i <= p.req;
              row_i <= p.row;
              col_i <= p.col;
              cell_kind_i <= p.kind;
              nxt_start = 1'b1;
            end
          end
          ACT_CFG: begin
            if (pending_resp_q.size() == 0 && !busy) begin
              void'(req_stream_q.pop_front());
              run_mode_i <= p.mode;
              nxt_we = 1'b1;
            end
          end
          default: begin
            if (pending_resp_q.size() == 0 && !busy) void'(req_stream_q.pop_front());
          end
        endcase
      end
      start <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  task automatic push_req(req_e req, int row, int col, int kind);
    stim_t s;
    s.act = ACT_REQ;
    s.req = req;
    s.row = row[4:0];
    s.col = col[4:0];
    s.kind = kind[2:0];
    s.mode = 1'b0;
    s.gap = phase_gap;
    req_stream_q.push_back(s);
  endtask

  task automatic push_ctl(act_e act, logic mode);
    stim_t s;
    s.act = act;
    s.req = REQ_READ;
    s.row = '0;
    s.col = '0;
    s.kind = '0;
    s.mode = mode;
    s.gap = 0;
    req_stream_q.push_back(s);
  endtask

  initial begin
    int   base_r;
    int   base_c;
    int   r;
    int   c;
    int   k;
    int   sel;
    int   lr;
    logic [2:0] kind;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, ignored kinds, edit-mode tick, small circuit, clear
    phase_gap = 0;
    push_ctl(ACT_CFG, 1'b0);
    push_req(REQ_READ, 0, 0, 0);
    push_req(REQ_WRITE, 0, 0, KSource);
    push_req(REQ_WRITE, 31, 31, KLampOff);
    push_req(REQ_WRITE, 0, 31, KWireOff);
    push_req(REQ_WRITE, 31, 0, 7);
    push_req(REQ_WRITE, 0, 0, 6);
    push_req(REQ_READ, 0, 0, 7);
    push_req(REQ_READ, 31, 0, 0);
    push_req(REQ_WRITE, 0, 1, KWireOff);
    push_req(REQ_WRITE, 0, 2, KWireOff);
    push_req(REQ_WRITE, 0, 3, KLampOff);
    push_req(REQ_WRITE, 5, 5, KWireOn);
    push_req(REQ_WRITE, 6, 6, KLampOn);
    push_req(REQ_TICK, 31, 31, 7);
    push_req(REQ_READ, 0, 2, 0);
    push_ctl(ACT_CFG, 1'b1);
    push_req(REQ_TICK, 0, 0, 0);
    push_req(REQ_READ, 0, 2, 0);
    push_req(REQ_READ, 0, 3, 0);
    push_req(REQ_READ, 0, 31, 0);
    push_req(REQ_READ, 5, 5, 0);
    push_req(REQ_READ, 6, 6, 0);
    push_req(REQ_CLEAR, 31, 31, 7);
    push_req(REQ_READ, 0, 0, 0);
    push_req(REQ_READ, 31, 31, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: phase_gap = 72;
        3: phase_gap = 24;
        default: phase_gap = 0;
      endcase
      push_ctl(ACT_CFG, ph != 1);
      base_r = $urandom_range(26);
      base_c = $urandom_range(26);
      for (int n = 0; n < 115; n++) begin
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0) begin
          r = $urandom_range(31);
          c = $urandom_range(31);
        end else begin
          r = base_r + $urandom_range(5);
          c = base_c + $urandom_range(5);
        end
        if (sel < 52) begin
          k = $urandom_range(99);
          if (k < 40) kind = KWireOff;
          else if (k < 50) kind = KSource;
          else if (k < 62) kind = KLampOff;
          else if (k < 70) kind = KWireOn;
          else if (k < 76) kind = KLampOn;
          else if (k < 86) kind = KEmpty;
          else if (k < 93) kind = 3'd6;
          else kind = 3'd7;
          push_req(REQ_WRITE, r, c, kind);
        end else if (sel < 82) begin
          push_req(REQ_READ, r, c, $urandom_range(7));
        end else if (sel < 94) begin
          push_req(REQ_TICK, $urandom_range(31), $urandom_range(31), $urandom_range(7));
        end else if (sel < 97) begin
          push_req(REQ_CLEAR, $urandom_range(31), $urandom_range(31), $urandom_range(7));
        end else begin
          base_r = $urandom_range(26);
          base_c = $urandom_range(26);
          push_req(REQ_READ, base_r, base_c, $urandom_range(7));
        end
        if (n == 70) push_ctl(ACT_DRAIN, 1'b0);
      end
      // a wire along a whole row, fed from one end
      lr = $urandom_range(31);
      push_req(REQ_WRITE, lr, 0, KSource);
      for (int j = 1; j < GridCols; j++) push_req(REQ_WRITE, lr, j, KWireOff);
      push_req(REQ_TICK, lr, 0, 0);
      push_req(REQ_READ, lr, 31, 0);
    end
    push_ctl(ACT_CFG, 1'b0);
    push_req(REQ_TICK, 0, 0, 0);
    push_req(REQ_READ, lr, 31, 0);

    while (req_stream_q.size() > 0 || start || pending_resp_q.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
